[rtl/abpd_pkg.sv]
// Shared types, constants and register codes of the acoustic beep peak detector.
package abpd_pkg;

  localparam int NUM_TONES     = 6;
  localparam int TONE_W        = 3;
  localparam int NODE_W        = 2;
  localparam int THRESH_W      = 16;
  localparam int SPAN_W        = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;

  localparam int AMP_BITS_DEF  = 16;
  localparam int TIME_BITS_DEF = 48;
  localparam int NUM_NODES_DEF = 3;

  localparam logic [THRESH_W-1:0] THRESH_RST    = THRESH_W'(32768);
  localparam logic [SPAN_W-1:0]   WINDOW_RST    = SPAN_W'(10000);
  localparam logic [SPAN_W-1:0]   QUIET_RST     = SPAN_W'(100000);
  localparam logic [TONE_W-1:0]   OWN_RST       = TONE_W'(2);
  localparam logic [TONE_W-1:0]   BCAST_RST     = TONE_W'(1);
  localparam logic [TONE_W-1:0]   START_RST     = TONE_W'(0);
  localparam logic [TONE_W-1:0]   FIRST_NODE_RST = TONE_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DETECT_THRESHOLD   = 3'd0,
    REG_PEAK_WINDOW        = 3'd1,
    REG_QUIET_AFTER_PEAK   = 3'd2,
    REG_OWN_TONE           = 3'd3,
    REG_BROADCAST_TONE     = 3'd4,
    REG_START_TONE         = 3'd5,
    REG_FIRST_NODE_TONE    = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_SPECTRUM = 1'b0,
    OP_RESUME   = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [THRESH_W-1:0] detect_threshold;
    logic [SPAN_W-1:0]   peak_window_us;
    logic [SPAN_W-1:0]   quiet_after_peak_us;
    logic [TONE_W-1:0]   own_tone_index;
    logic [TONE_W-1:0]   broadcast_tone_index;
    logic [TONE_W-1:0]   start_tone_index;
    logic [TONE_W-1:0]   first_node_tone_index;
  } cfg_t;

  typedef struct packed {
    logic              respond_request;
    logic              delay_valid;
    logic [NODE_W-1:0] delay_node;
    logic              searching;
    logic              beep_done;
    logic [TONE_W-1:0] tone_index;
  } res_flags_t;

endpackage

[rtl/acoustic_beep_peak_detector_top.sv]
// Top level of the acoustic beep peak detector: handshakes, registers and datapath.
//
// One spectrum update (or transmit-finished event) enters per clock, unless the
// result register is held by out_ready, and yields exactly one result item. The
// block sustains one item per cycle while results are taken. An item is held in
// the input register and moves into the result register at the first edge at
// which the result register is empty or its item is taken at that edge. Its result
// is then offered from the result register. The rate is set by the detector
// state loop, which is updated once per item: a six-way threshold compare, an
// amplitude compare and a few time-stamp adds and compares. Configuration
// writes are always taken (cfg_ready is tied high) and must only be issued
// while no item is in flight. Writes to an index past the last register are
// dropped. Time sums wrap modulo 2**TIME_BITS.
module acoustic_beep_peak_detector_top import abpd_pkg::*; #(
  parameter int AMP_BITS  = AMP_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int NUM_NODES = NUM_NODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input item channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [TIME_BITS-1:0]  now_us,
  input  logic [AMP_BITS-1:0]   amp_0,
  input  logic [AMP_BITS-1:0]   amp_1,
  input  logic [AMP_BITS-1:0]   amp_2,
  input  logic [AMP_BITS-1:0]   amp_3,
  input  logic [AMP_BITS-1:0]   amp_4,
  input  logic [AMP_BITS-1:0]   amp_5,
  // result item channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  respond_request,
  output logic                  delay_valid,
  output logic [NODE_W-1:0]     delay_node,
  output logic [TIME_BITS-1:0]  delay_us,
  output logic                  searching,
  output logic                  beep_done,
  output logic [TONE_W-1:0]     tone_index
);

  cfg_t cfg;

  // input register
  logic                              in_full;
  logic                              opcode_r;
  logic [TIME_BITS-1:0]              now_r;
  logic [NUM_TONES-1:0][AMP_BITS-1:0] amp_r;

  logic advance;

  logic                 hit;
  logic [TONE_W-1:0]    hit_tone;
  logic [AMP_BITS-1:0]  hit_amp;
  logic [AMP_BITS-1:0]  cur_amp;
  logic [TONE_W-1:0]    current_tone;
  res_flags_t           flags;
  logic [TIME_BITS-1:0] delay_calc;

  // Advance the held item into the result register whenever that register is
  // empty or its item is being taken this cycle.
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_threshold      <= THRESH_RST;
      cfg.peak_window_us        <= WINDOW_RST;
      cfg.quiet_after_peak_us   <= QUIET_RST;
      cfg.own_tone_index        <= OWN_RST;
      cfg.broadcast_tone_index  <= BCAST_RST;
      cfg.start_tone_index      <= START_RST;
      cfg.first_node_tone_index <= FIRST_NODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DETECT_THRESHOLD: cfg.detect_threshold      <= cfg_data[THRESH_W-1:0];
        REG_PEAK_WINDOW:      cfg.peak_window_us        <= cfg_data[SPAN_W-1:0];
        REG_QUIET_AFTER_PEAK: cfg.quiet_after_peak_us   <= cfg_data[SPAN_W-1:0];
        REG_OWN_TONE:         cfg.own_tone_index        <= cfg_data[TONE_W-1:0];
        REG_BROADCAST_TONE:   cfg.broadcast_tone_index  <= cfg_data[TONE_W-1:0];
        REG_START_TONE:       cfg.start_tone_index      <= cfg_data[TONE_W-1:0];
        REG_FIRST_NODE_TONE:  cfg.first_node_tone_index <= cfg_data[TONE_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // input register: hold until the item advances
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opcode_r <= opcode;
      now_r    <= now_us;
      amp_r[0] <= amp_0;
      amp_r[1] <= amp_1;
      amp_r[2] <= amp_2;
      amp_r[3] <= amp_3;
      amp_r[4] <= amp_4;
      amp_r[5] <= amp_5;
    end
  end

  abpd_detect #(
    .AMP_BITS (AMP_BITS)
  ) u_detect (
    .amps         (amp_r),
    .threshold    (cfg.detect_threshold),
    .current_tone (current_tone),
    .hit          (hit),
    .hit_tone     (hit_tone),
    .hit_amp      (hit_amp),
    .cur_amp      (cur_amp)
  );

  abpd_core #(
    .AMP_BITS  (AMP_BITS),
    .TIME_BITS (TIME_BITS),
    .NUM_NODES (NUM_NODES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fire         (advance),
    .opcode       (opcode_r),
    .now_us       (now_r),
    .hit          (hit),
    .hit_tone     (hit_tone),
    .hit_amp      (hit_amp),
    .cur_amp      (cur_amp),
    .current_tone (current_tone),
    .flags        (flags),
    .delay_us     (delay_calc)
  );

  // result register: valid drops once the item is taken and nothing follows
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      respond_request <= flags.respond_request;
      delay_valid     <= flags.delay_valid;
      delay_node      <= flags.delay_node;
      delay_us        <= delay_calc;
      searching       <= flags.searching;
      beep_done       <= flags.beep_done;
      tone_index      <= flags.tone_index;
    end
  end

endmodule

[rtl/abpd_detect.sv]
// Per-tone threshold compare, lowest-tone pick and current-tone amplitude select.
module abpd_detect import abpd_pkg::*; #(
  parameter int AMP_BITS = AMP_BITS_DEF
) (
  input  logic [NUM_TONES-1:0][AMP_BITS-1:0] amps,
  input  logic [THRESH_W-1:0]                threshold,
  input  logic [TONE_W-1:0]                  current_tone,
  output logic                               hit,
  output logic [TONE_W-1:0]                  hit_tone,
  output logic [AMP_BITS-1:0]                hit_amp,
  output logic [AMP_BITS-1:0]                cur_amp
);

  localparam int CMP_W = (AMP_BITS > THRESH_W) ? AMP_BITS : THRESH_W;

  logic [NUM_TONES-1:0] above;

  always_comb begin
    for (int i = 0; i < NUM_TONES; i++) begin
      above[i] = CMP_W'(amps[i]) > CMP_W'(threshold);
    end
  end

  // lowest tone index wins
  always_comb begin
    hit      = |above;
    hit_tone = '0;
    hit_amp  = '0;
    for (int i = NUM_TONES - 1; i >= 0; i--) begin
      if (above[i]) begin
        hit_tone = TONE_W'(i);
        hit_amp  = amps[i];
      end
    end
  end

  always_comb begin
    cur_amp = '0;
    for (int i = 0; i < NUM_TONES; i++) begin
      if (current_tone == TONE_W'(i)) begin
        cur_amp = amps[i];
      end
    end
  end

endmodule

[rtl/abpd_core.sv]
// Detector state, peak search and beep classification, one item per cycle when fire is high.
module abpd_core import abpd_pkg::*; #(
  parameter int AMP_BITS  = AMP_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int NUM_NODES = NUM_NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 fire,
  input  logic                 opcode,
  input  logic [TIME_BITS-1:0] now_us,
  input  logic                 hit,
  input  logic [TONE_W-1:0]    hit_tone,
  input  logic [AMP_BITS-1:0]  hit_amp,
  input  logic [AMP_BITS-1:0]  cur_amp,
  output logic [TONE_W-1:0]    current_tone,
  output res_flags_t           flags,
  output logic [TIME_BITS-1:0] delay_us
);

  logic                 transmitting, transmitting_next;
  logic                 search_active, search_active_next;
  logic [TONE_W-1:0]    current_tone_next;
  logic [TONE_W-1:0]    previous_tone, previous_tone_next;
  logic [AMP_BITS-1:0]  peak_amplitude, peak_amplitude_next;
  logic [TIME_BITS-1:0] peak_time, peak_time_next;
  logic [TIME_BITS-1:0] window_end, window_end_next;
  logic [TIME_BITS-1:0] listen_from, listen_from_next;
  logic [TIME_BITS-1:0] other_node_time, other_node_time_next;

  logic [TONE_W-1:0] cur_off, prev_off;
  logic              cur_is_node, prev_is_node;

  assign cur_off      = current_tone - cfg.first_node_tone_index;
  assign prev_off     = previous_tone - cfg.first_node_tone_index;
  assign cur_is_node  = (current_tone >= cfg.first_node_tone_index) && (cur_off < NUM_NODES);
  assign prev_is_node = (previous_tone >= cfg.first_node_tone_index) && (prev_off < NUM_NODES);

  always_comb begin
    transmitting_next    = transmitting;
    search_active_next   = search_active;
    current_tone_next    = current_tone;
    previous_tone_next   = previous_tone;
    peak_amplitude_next  = peak_amplitude;
    peak_time_next       = peak_time;
    window_end_next      = window_end;
    listen_from_next     = listen_from;
    other_node_time_next = other_node_time;
    flags                = '0;
    delay_us             = '0;

    if (opcode == OP_RESUME) begin
      transmitting_next = 1'b0;
    end else if (!transmitting && (now_us >= listen_from)) begin
      if (search_active) begin
        if (now_us >= window_end) begin
          // window closed: classify the beep
          flags.beep_done = 1'b1;
          if ((current_tone == cfg.own_tone_index) ||
              (current_tone == cfg.broadcast_tone_index)) begin
            flags.respond_request = 1'b1;
            transmitting_next     = 1'b1;
          end else if (cur_is_node) begin
            other_node_time_next = peak_time;
          end else if (current_tone == cfg.start_tone_index) begin
            if (prev_is_node) begin
              flags.delay_valid = 1'b1;
              flags.delay_node  = prev_off[NODE_W-1:0];
              delay_us          = peak_time - other_node_time;
            end
          end
          previous_tone_next  = current_tone;
          peak_amplitude_next = '0;
          search_active_next  = 1'b0;
          listen_from_next    = peak_time + TIME_BITS'(cfg.quiet_after_peak_us);
        end else if (cur_amp > peak_amplitude) begin
          peak_amplitude_next = cur_amp;
          peak_time_next      = now_us;
        end
      end else if (hit) begin
        peak_amplitude_next = hit_amp;
        peak_time_next      = now_us;
        current_tone_next   = hit_tone;
        window_end_next     = now_us + TIME_BITS'(cfg.peak_window_us);
        search_active_next  = 1'b1;
      end
    end

    flags.searching  = search_active_next;
    flags.tone_index = current_tone_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transmitting    <= 1'b0;
      search_active   <= 1'b0;
      current_tone    <= '0;
      previous_tone   <= '0;
      peak_amplitude  <= '0;
      peak_time       <= '0;
      window_end      <= '0;
      listen_from     <= '0;
      other_node_time <= '0;
    end else if (fire) begin
      transmitting    <= transmitting_next;
      search_active   <= search_active_next;
      current_tone    <= current_tone_next;
      previous_tone   <= previous_tone_next;
      peak_amplitude  <= peak_amplitude_next;
      peak_time       <= peak_time_next;
      window_end      <= window_end_next;
      listen_from     <= listen_from_next;
      other_node_time <= other_node_time_next;
    end
  end

  a_respond_enters_tx: assert property (@(posedge clk) disable iff (rst)
    fire && flags.respond_request |=> transmitting)
    else $error("respond request did not enter transmitting");

  a_delay_on_start_close: assert property (@(posedge clk) disable iff (rst)
    fire && flags.delay_valid |-> flags.beep_done && (current_tone == cfg.start_tone_index))
    else $error("delay reported outside a start-tone close");

  a_done_stops_search: assert property (@(posedge clk) disable iff (rst)
    fire && flags.beep_done |=> !search_active && (previous_tone == $past(current_tone)))
    else $error("closed search left active");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !fire && !rst |=> $stable(peak_time) && $stable(listen_from) && $stable(search_active))
    else $error("state changed without an item");

endmodule
